@@ rtl/indexed_list_insert_delete_assert.svh @@
// ---------------------------------------------------------------------------
// Indexed list assertion macros
// Shared property forms for the indexed list checker.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define ILD_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list check failed: same-cycle property");

// Consequent holds in the cycle after the antecedent
`define ILD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list check failed: next-cycle property");

`endif

@@ rtl/ild_pkg.sv @@
// ---------------------------------------------------------------------------
// Indexed list package
// Field widths, request modes, status codes and transfer structs.
// ---------------------------------------------------------------------------
package ild_pkg;

  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] list_length;
    logic [ST_W-1:0]  status;
  } rsp_t;

endpackage

@@ rtl/indexed_list_insert_delete.sv @@
// ---------------------------------------------------------------------------
// Indexed list with insert and delete
// Ordered list of up to CAPACITY words in a single-port memory, with a
// length count; append, insert, read and delete requests.
// ---------------------------------------------------------------------------
//  channel   handshake          payload   notes
//  request   start, busy        req       taken when start && !busy
//  result    done               rsp       one-cycle strobe, no backpressure
//
//  Insert and delete shift the entries behind the position one slot at a time;
//  the memory moves each entry with a read (S_SHIFT_RD) then a write
//  (S_SHIFT_WR), and insert then writes the new item (S_PUT). Read waits in
//  S_RD_WAIT for the registered memory data. busy stays high until the cycle
//  after done, so a new request is taken only after the result.
//  Reset (rst, synchronous) empties the list; memory contents are not cleared.
//  done is not stalled by the receiver.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete
  import ild_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_BITS = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EVAL     = 7'b0000010,
    S_SHIFT_RD = 7'b0000100,
    S_SHIFT_WR = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_RD_WAIT  = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] cursor, cursor_next;
  req_t req_q, req_q_next;
  logic [VAL_W-1:0] result_value, result_value_next;
  logic [ST_W-1:0] result_status, result_status_next;

  // Memory and its port controls
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] wr_data;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic wr_en, rd_en;

  // Shared pointer arithmetic
  logic [CNT_W-1:0] cursor_m1, cursor_p1;
  logic [CMP_W-1:0] pos_ext, count_ext, count_m1_ext, cursor_m1_ext, cursor_p1_ext;
  logic [ADDR_W-1:0] pos_addr;
  logic is_insert, count_full;
  logic [VALUE_BITS-1:0] val_in;
  logic [VAL_W-1:0] rd_out;

  assign cursor_m1     = CNT_W'(cursor - 1'b1);
  assign cursor_p1     = CNT_W'(cursor + 1'b1);
  assign pos_ext       = CMP_W'(req_q.position);
  assign count_ext     = CMP_W'(count);
  assign count_m1_ext  = CMP_W'(count_ext - 1'b1);
  assign cursor_m1_ext = CMP_W'(cursor_m1);
  assign cursor_p1_ext = CMP_W'(cursor_p1);
  assign pos_addr      = pos_ext[ADDR_W-1:0];
  assign is_insert     = (req_q.mode == MODE_INSERT);
  assign count_full    = (count_ext >= CMP_W'(CAPACITY));

  // Fit the request value to the stored width and the stored word to the port
  always_comb begin
    val_in = '0;
    rd_out = '0;
    for (int k = 0; k < IN_BITS; k++) begin
      val_in[k] = req_q.item_value[k];
      rd_out[k] = rdata[k];
    end
  end

  // Sequencer
  always_comb begin
    state_next         = state;
    count_next         = count;
    cursor_next        = cursor;
    req_q_next         = req_q;
    result_value_next  = result_value;
    result_status_next = result_status;
    wr_en              = 1'b0;
    wr_addr            = cursor[ADDR_W-1:0];
    wr_data            = rdata;
    rd_en              = 1'b0;
    rd_addr            = cursor_m1[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          req_q_next = req;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        result_value_next  = '0;
        result_status_next = ST_OK;
        state_next         = S_RESP;
        case (req_q.mode)
          MODE_APPEND: begin
            if (count_full) begin
              result_status_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = count[ADDR_W-1:0];
              wr_data    = val_in;
              count_next = CNT_W'(count + 1'b1);
            end
          end
          MODE_INSERT: begin
            if (pos_ext > count_ext) begin
              result_status_next = ST_RANGE;
            end else if (count_full) begin
              result_status_next = ST_FULL;
            end else begin
              cursor_next = count;
              state_next  = (count_ext > pos_ext) ? S_SHIFT_RD : S_PUT;
            end
          end
          MODE_READ: begin
            if (pos_ext >= count_ext) begin
              result_status_next = ST_RANGE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = pos_addr;
              state_next = S_RD_WAIT;
            end
          end
          default: begin
            // delete
            if (pos_ext >= count_ext) begin
              result_status_next = ST_RANGE;
            end else begin
              cursor_next = pos_ext[CNT_W-1:0];
              if (pos_ext < count_m1_ext) begin
                state_next = S_SHIFT_RD;
              end else begin
                count_next = CNT_W'(count - 1'b1);
              end
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        // fetch the neighbor that moves into the cursor slot
        rd_en      = 1'b1;
        rd_addr    = is_insert ? cursor_m1[ADDR_W-1:0] : cursor_p1[ADDR_W-1:0];
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = cursor[ADDR_W-1:0];
        wr_data = rdata;
        if (is_insert) begin
          cursor_next = cursor_m1;
          state_next  = (cursor_m1_ext > pos_ext) ? S_SHIFT_RD : S_PUT;
        end else begin
          cursor_next = cursor_p1;
          if (cursor_p1_ext < count_m1_ext) begin
            state_next = S_SHIFT_RD;
          end else begin
            count_next = CNT_W'(count - 1'b1);
            state_next = S_RESP;
          end
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = pos_addr;
        wr_data    = val_in;
        count_next = CNT_W'(count + 1'b1);
        state_next = S_RESP;
      end
      S_RD_WAIT: begin
        result_value_next = rd_out;
        state_next        = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cursor        <= cursor_next;
    req_q         <= req_q_next;
    result_value  <= result_value_next;
    result_status <= result_status_next;
  end

  // Single-port list memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Drive the ports
  assign busy             = (state != S_IDLE);
  assign done             = (state == S_RESP);
  assign rsp.read_value   = result_value;
  assign rsp.list_length  = LEN_W'(count);
  assign rsp.status       = result_status;

endmodule

@@ rtl/ild_check.sv @@
// ---------------------------------------------------------------------------
// Indexed list port checker
// Watches the request and result ports of the indexed list over time.
// ---------------------------------------------------------------------------
`include "indexed_list_insert_delete_assert.svh"

module ild_check
  import ild_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  // An accepted transfer makes the block busy
  `ILD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The result strobe lasts one cycle
  `ILD_ASSERT_NEXT(a_done_single, done, !done)
  // The block frees up only right after a result
  `ILD_ASSERT_SAME(a_free_after_done, $fell(busy), $past(done))
  // Only a successful read carries data
  `ILD_ASSERT_SAME(a_value_zero, done && (rsp.status != ST_OK), rsp.read_value == '0)

endmodule

bind indexed_list_insert_delete ild_check u_ild_check (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Indexed list testbench
// Runs append, insert, read and delete requests through the list block. A
// shadow copy of the list predicts each response when its request transfers,
// and every response strobe is compared field by field with the oldest
// prediction. Directed boundary requests come first. Random requests follow,
// with the list swept between empty and full.
// ---------------------------------------------------------------------------
module tb_top;
  import ild_pkg::*;

  localparam int CAP        = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 16;

  // Shadow of the list contents; predicts and checks responses
  class list_shadow;
    logic [VAL_W-1:0] words[CAP];
    int               length;
    rsp_t             owed_rsp[$];
    int               errors;

    function new();
      length = 0;
      errors = 0;
    endfunction

    // Apply one transferred request and queue the response it owes
    function void note_request(req_t r);
      rsp_t e;
      int   p;
      e = '0;
      p = int'(r.position);
      case (r.mode)
        MODE_APPEND: begin
          if (length >= CAP) begin
            e.status = ST_FULL;
          end else begin
            words[length] = r.item_value;
            length++;
          end
        end
        MODE_INSERT: begin
          if (p > length) begin
            e.status = ST_RANGE;
          end else if (length >= CAP) begin
            e.status = ST_FULL;
          end else begin
            for (int i = length; i > p; i--) words[i] = words[i-1];
            words[p] = r.item_value;
            length++;
          end
        end
        MODE_READ: begin
          if (p >= length) e.status = ST_RANGE;
          else e.read_value = words[p];
        end
        default: begin
          if (p >= length) begin
            e.status = ST_RANGE;
          end else begin
            for (int i = p; i + 1 < length; i++) words[i] = words[i+1];
            length--;
          end
        end
      endcase
      e.list_length = length[LEN_W-1:0];
      owed_rsp.push_back(e);
    endfunction

    // Compare one response strobe with the oldest owed response
    function void check_response(rsp_t a);
      rsp_t e;
      if (owed_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] response with no request owed: value=%h len=%0d status=%0d",
                   $realtime, a.read_value, a.list_length, a.status);
        return;
      end
      e = owed_rsp.pop_front();
      if (a.read_value !== e.read_value || a.list_length !== e.list_length ||
          a.status !== e.status) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] mismatch: exp value=%h len=%0d status=%0d, ",
                    "got value=%h len=%0d status=%0d"},
                   $realtime, e.read_value, e.list_length, e.status,
                   a.read_value, a.list_length, a.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  list_shadow shadow;
  int         send_idle_pct;
  int         idle_cycles;

  indexed_list_insert_delete #(
    .CAPACITY  (CAP),
    .VALUE_BITS(VAL_W)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels at the rising edge; response first, then request
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) shadow.check_response(rsp);
      if (start && !busy) shadow.note_request(req);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop a hung run
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t make_req(logic [MODE_W-1:0] m, int p, logic [VAL_W-1:0] v);
    req_t r;
    r.mode       = m;
    r.position   = p[POS_W-1:0];
    r.item_value = v;
    return r;
  endfunction

  // Pick a request: mostly valid positions, biased toward growing or shrinking
  function automatic req_t pick_request(int len, bit growing);
    req_t r;
    int   roll;
    int   p;
    r.item_value = $urandom();
    r.position   = POS_W'($urandom_range(0, 127));
    r.mode       = MODE_W'($urandom_range(0, 3));
    roll         = $urandom_range(0, 99);
    // noise: fully random request
    if (roll < 5) return r;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 45) r.mode = MODE_APPEND;
      else if (roll < 80) r.mode = MODE_INSERT;
      else if (roll < 92) r.mode = MODE_READ;
      else r.mode = MODE_DELETE;
    end else begin
      if (roll < 5) r.mode = MODE_APPEND;
      else if (roll < 15) r.mode = MODE_INSERT;
      else if (roll < 30) r.mode = MODE_READ;
      else r.mode = MODE_DELETE;
    end
    if ($urandom_range(0, 9) == 0) begin
      // boundary positions around the current length and the top of the field
      case ($urandom_range(0, 4))
        0: p = len;
        1: p = len + 1;
        2: p = 127;
        3: p = CAP - 1;
        default: p = CAP;
      endcase
    end else if (r.mode == MODE_INSERT) begin
      p = $urandom_range(0, len);
    end else if (len > 0) begin
      p = $urandom_range(0, len - 1);
    end else begin
      p = 0;
    end
    r.position = p[POS_W-1:0];
    return r;
  endfunction

  // Present one request from a falling edge and hold it until it transfers
  task automatic issue(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random requests, sweeping the list length between empty and full
  task automatic run_random(int count, int idle_pct);
    bit growing;
    growing       = 1'b1;
    send_idle_pct = idle_pct;
    repeat (count) begin
      if (shadow.length >= CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (shadow.length == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) == 0) growing = ~growing;
      issue(pick_request(shadow.length, growing));
    end
  endtask

  initial begin
    shadow        = new();
    send_idle_pct = 0;
    idle_cycles   = 0;
    rst           = 1'b1;
    start         = 1'b0;
    req           = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, both ends of the list, out-of-range positions
    send_idle_pct = 16;
    issue(make_req(MODE_READ,   0,   32'h1111_1111));
    issue(make_req(MODE_DELETE, 0,   32'h2222_2222));
    issue(make_req(MODE_INSERT, 1,   32'h3333_3333));
    issue(make_req(MODE_INSERT, 0,   32'h0000_0000));
    issue(make_req(MODE_APPEND, 0,   32'hFFFF_FFFF));
    issue(make_req(MODE_INSERT, 2,   32'h1234_5678));
    issue(make_req(MODE_INSERT, 0,   32'hA5A5_A5A5));
    issue(make_req(MODE_INSERT, 127, 32'hDEAD_BEEF));
    issue(make_req(MODE_READ,   0,   32'hFFFF_FFFF));
    issue(make_req(MODE_READ,   3,   32'h0));
    issue(make_req(MODE_READ,   4,   32'h0));
    issue(make_req(MODE_READ,   127, 32'h0));
    issue(make_req(MODE_DELETE, 1,   32'hFFFF_FFFF));
    issue(make_req(MODE_DELETE, 2,   32'h0));
    issue(make_req(MODE_DELETE, 64,  32'h0));
    issue(make_req(MODE_READ,   1,   32'h0));
    issue(make_req(MODE_APPEND, 127, 32'h5A5A_5A5A));
    issue(make_req(MODE_READ,   2,   32'h0));
    issue(make_req(MODE_DELETE, 0,   32'h0));
    issue(make_req(MODE_DELETE, 0,   32'h0));
    issue(make_req(MODE_DELETE, 0,   32'h0));
    issue(make_req(MODE_DELETE, 0,   32'h0));
    issue(make_req(MODE_READ,   0,   32'h0));

    // Random: light sender gaps, then heavy gaps, then back to back
    run_random(126, 16);
    run_random(126, 78);
    run_random(126, 0);
    start <= 1'b0;

    // Drain owed responses, then watch for stray strobes
    while (shadow.owed_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (shadow.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ indexed_list_insert_delete.f @@
+incdir+rtl
rtl/ild_pkg.sv
rtl/indexed_list_insert_delete.sv
rtl/ild_check.sv
tb/tb_top.sv
